>>> hdl/lrbd_pkg.sv
package lrbd_pkg;

	localparam int unsigned BUFFER_DEPTH = 1024;
	localparam int unsigned PAYLOAD_CAP = 64;
	localparam int unsigned MP_W = 7;

	localparam logic [1:0] KIND_PUT = 2'd0;
	localparam logic [1:0] KIND_DRAIN = 2'd1;
	localparam logic [1:0] KIND_SET = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_in;
		logic       enable;
		logic [7:0] token;
	} item_t;

	typedef struct packed {
		logic [7:0] token_out;
		logic [7:0] data_out;
		logic       is_flags;
		logic       last;
	} resp_t;

	typedef enum logic [1:0] {
		OP_PUT,
		OP_DRAIN,
		OP_SET
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       enable;
		logic [7:0] token;
	} cmd_t;

endpackage

>>> hdl/lrbd_ram.sv
module lrbd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = lrbd_pkg::BUFFER_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/lrbd_front.sv
module lrbd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  lrbd_pkg::item_t item,
	output logic            cmd_valid,
	output lrbd_pkg::cmd_t  cmd,
	input  logic            cmd_pop
);

	lrbd_pkg::cmd_t cmd_q [2];
	logic [1:0]     cnt_q;
	logic           wp_q;
	logic           rp_q;
	lrbd_pkg::cmd_t cmd_new;
	logic           keep;
	logic           push;

	always_comb begin
		cmd_new.data = item.byte_in;
		cmd_new.enable = item.enable;
		cmd_new.token = item.token;
		cmd_new.op = lrbd_pkg::OP_PUT;
		keep = 1'b1;
		unique case (item.kind)
			lrbd_pkg::KIND_PUT: cmd_new.op = lrbd_pkg::OP_PUT;
			lrbd_pkg::KIND_DRAIN: cmd_new.op = lrbd_pkg::OP_DRAIN;
			lrbd_pkg::KIND_SET: cmd_new.op = lrbd_pkg::OP_SET;
			default: keep = 1'b0;
		endcase
	end

	assign item_stall = (cnt_q == 2'd2);
	assign push = item_valid && !item_stall && keep;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = cmd_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (cmd_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wp_q] <= cmd_new;
		end
	end

endmodule

>>> hdl/lrbd_back.sv
module lrbd_back #(
	parameter int unsigned DEPTH = lrbd_pkg::BUFFER_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [lrbd_pkg::MP_W-1:0] cfg_wdata,
	input  logic                      cmd_valid,
	input  lrbd_pkg::cmd_t            cmd,
	output logic                      cmd_pop,
	output logic                      resp_valid,
	input  logic                      resp_stall,
	output lrbd_pkg::resp_t           resp
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(lrbd_pkg::PAYLOAD_CAP);
	localparam int unsigned CMP_W = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [AW:0] DEPTH_V = (AW + 1)'(DEPTH);
	localparam logic [lrbd_pkg::MP_W-1:0] CAP_V = lrbd_pkg::MP_W'(lrbd_pkg::PAYLOAD_CAP);

	typedef enum logic {S_IDLE, S_DRAIN} state_t;

	state_t                    st_q;
	logic [AW-1:0]             wi_q;
	logic [AW-1:0]             ri_q;
	logic                      holds_q;
	logic                      ovf_q;
	logic                      on_q;
	logic [lrbd_pkg::MP_W-1:0] mp_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [7:0]                tok_q;
	logic                      infl_q;
	logic                      infl_last_q;

	lrbd_pkg::resp_t oq_q [4];
	logic [1:0]      oq_wp_q;
	logic [1:0]      oq_rp_q;
	logic [2:0]      oq_cnt_q;

	logic                      full;
	logic [AW-1:0]             ri_eff;
	logic [AW-1:0]             wi_nxt;
	logic [AW-1:0]             ri_nxt;
	logic                      fill;
	logic [AW:0]               avail;
	logic [lrbd_pkg::MP_W-1:0] limit;
	logic [CNT_W-1:0]          room;
	logic [CNT_W-1:0]          n;
	logic                      credit_ok;
	logic                      take;
	logic                      issue;
	logic                      ram_we;
	logic [7:0]                ram_wdata;
	logic [7:0]                ram_rdata;
	logic                      flag_push;
	logic                      oq_push;
	logic                      oq_pop;
	lrbd_pkg::resp_t           oq_new;

	assign full = holds_q && (wi_q == ri_q);
	assign ri_eff = holds_q ? ri_q : wi_q;
	assign wi_nxt = (wi_q == LAST_IDX) ? '0 : wi_q + AW'(1);
	assign ri_nxt = (ri_q == LAST_IDX) ? '0 : ri_q + AW'(1);
	assign fill = (wi_nxt == ri_eff);

	always_comb begin
		if (!holds_q) begin
			avail = '0;
		end else if (wi_q == ri_q) begin
			avail = DEPTH_V;
		end else if (wi_q > ri_q) begin
			avail = {1'b0, wi_q} - {1'b0, ri_q};
		end else begin
			avail = {1'b0, wi_q} + DEPTH_V - {1'b0, ri_q};
		end
	end

	always_comb begin
		if (mp_q == '0) begin
			limit = lrbd_pkg::MP_W'(1);
		end else if (mp_q > CAP_V) begin
			limit = CAP_V;
		end else begin
			limit = mp_q;
		end
	end

	assign room = CNT_W'(limit - lrbd_pkg::MP_W'(1));
	assign n = (CMP_W'(avail) < CMP_W'(room)) ? CNT_W'(avail) : room;

	assign credit_ok = ({1'b0, oq_cnt_q} + {3'b000, infl_q}) < 4'd4;
	assign take = (st_q == S_IDLE) && cmd_valid && !infl_q
		&& ((cmd.op != lrbd_pkg::OP_DRAIN) || credit_ok);
	assign cmd_pop = take;
	assign issue = (st_q == S_DRAIN) && credit_ok;

	assign ram_we = take && (cmd.op == lrbd_pkg::OP_PUT) && on_q && !full;
	assign ram_wdata = fill ? 8'd0 : cmd.data;

	lrbd_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(wi_q),
		.wdata(ram_wdata),
		.re(issue),
		.raddr(ri_q),
		.rdata(ram_rdata)
	);

	assign flag_push = take && (cmd.op == lrbd_pkg::OP_DRAIN);
	assign oq_push = flag_push || infl_q;
	assign resp_valid = (oq_cnt_q != 3'd0);
	assign resp = oq_q[oq_rp_q];
	assign oq_pop = resp_valid && !resp_stall;

	always_comb begin
		if (flag_push) begin
			oq_new.token_out = cmd.token;
			oq_new.data_out = {7'd0, ovf_q};
			oq_new.is_flags = 1'b1;
			oq_new.last = (n == '0);
		end else begin
			oq_new.token_out = tok_q;
			oq_new.data_out = ram_rdata;
			oq_new.is_flags = 1'b0;
			oq_new.last = infl_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			wi_q <= '0;
			ri_q <= '0;
			holds_q <= 1'b0;
			ovf_q <= 1'b0;
			on_q <= 1'b0;
			mp_q <= CAP_V;
			cnt_q <= '0;
			tok_q <= 8'd0;
			infl_q <= 1'b0;
			infl_last_q <= 1'b0;
			oq_wp_q <= 2'd0;
			oq_rp_q <= 2'd0;
			oq_cnt_q <= 3'd0;
		end else begin
			if (cfg_we) begin
				mp_q <= cfg_wdata;
			end
			infl_q <= issue;
			infl_last_q <= (cnt_q == CNT_W'(1));
			unique case (st_q)
				S_IDLE: begin
					if (take) begin
						unique case (cmd.op)
							lrbd_pkg::OP_PUT: begin
								if (on_q && !full) begin
									ri_q <= ri_eff;
									holds_q <= 1'b1;
									wi_q <= wi_nxt;
									if (fill) begin
										ovf_q <= 1'b1;
									end
								end
							end
							lrbd_pkg::OP_SET: begin
								if (cmd.enable != on_q) begin
									on_q <= cmd.enable;
									ovf_q <= 1'b0;
									wi_q <= '0;
									ri_q <= '0;
									holds_q <= 1'b0;
								end
							end
							lrbd_pkg::OP_DRAIN: begin
								ovf_q <= 1'b0;
								tok_q <= cmd.token;
								if (n != '0) begin
									cnt_q <= n;
									st_q <= S_DRAIN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DRAIN: begin
					if (issue) begin
						ri_q <= ri_nxt;
						cnt_q <= cnt_q - CNT_W'(1);
						if (cnt_q == CNT_W'(1)) begin
							st_q <= S_IDLE;
							if (ri_nxt == wi_q) begin
								wi_q <= '0;
								ri_q <= '0;
								holds_q <= 1'b0;
							end
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
			if (oq_push) begin
				oq_wp_q <= oq_wp_q + 2'd1;
			end
			if (oq_pop) begin
				oq_rp_q <= oq_rp_q + 2'd1;
			end
			oq_cnt_q <= oq_cnt_q + {2'b00, oq_push} - {2'b00, oq_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[oq_wp_q] <= oq_new;
		end
	end

endmodule

>>> hdl/log_ring_buffer_with_drain.sv
// Log byte ring buffer with drain.
// Item channel (item_valid / item_stall / item): put, drain or set-state
// requests; a transfer happens when item_valid is high and item_stall low.
// A two-entry command queue takes one item per cycle; item_stall rises only
// when that queue is full. Kind 3 items are taken and dropped.
// Back end: a put or set-state is done in the cycle it is taken. A drain sends
// the flags byte and then each buffered byte, as the single read port
// of the store yields one byte per cycle while the response queue has room;
// no new command is taken while the last store read is still in flight.
// Response channel (resp_valid / resp_stall / resp): the flags byte comes first,
// then the buffered bytes from registered store reads, one byte per cycle while
// resp_stall stays low, the last one marked.
// A four-entry response queue absorbs resp_stall; store reads pause while
// it is full, and items still flow in until the command queue fills.
// cfg_we / cfg_wdata write max_payload; write it only while idle.
// Reset: logging off, buffer empty, overflow clear, max_payload 64. No
// clearing pass is needed; the block is ready as soon as reset is released.
module log_ring_buffer_with_drain #(
	parameter int unsigned BUFFER_DEPTH = lrbd_pkg::BUFFER_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  lrbd_pkg::item_t           item,
	output logic                      resp_valid,
	input  logic                      resp_stall,
	output lrbd_pkg::resp_t           resp,
	input  logic                      cfg_we,
	input  logic [lrbd_pkg::MP_W-1:0] cfg_wdata
);

	logic           cmd_valid;
	lrbd_pkg::cmd_t cmd;
	logic           cmd_pop;

	lrbd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	lrbd_back #(
		.DEPTH(BUFFER_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.resp_valid(resp_valid),
		.resp_stall(resp_stall),
		.resp(resp)
	);

`ifndef ASSERT_OFF
	a_flags_clean: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && resp.is_flags |-> resp.data_out[7:1] == 7'd0)
		else $error("flags byte carries stray bits");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

	a_cmd_queued: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.kind == lrbd_pkg::KIND_PUT
		|| item.kind == lrbd_pkg::KIND_DRAIN || item.kind == lrbd_pkg::KIND_SET)
		|=> cmd_valid)
		else $error("accepted item missing from command queue");
`endif

endmodule

>>> tb/tb_log_ring_buffer_with_drain.sv
`timescale 1ns / 1ps

module tb_log_ring_buffer_with_drain;

	localparam logic [1:0] KIND_PUT = lrbd_pkg::KIND_PUT;
	localparam logic [1:0] KIND_DRAIN = lrbd_pkg::KIND_DRAIN;
	localparam logic [1:0] KIND_SET = lrbd_pkg::KIND_SET;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int unsigned WATCHDOG_CYCLES = 300000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned LONG_HOLD_CYCLES = 90;
	localparam logic [15:0] STALL_PATTERN = 16'hC3A5;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t                 what;
		lrbd_pkg::item_t           it;
		logic [lrbd_pkg::MP_W-1:0] cfg;
		logic                      typed;
		lrbd_pkg::resp_t           exp;
	} step_row_t;

	localparam lrbd_pkg::item_t NO_ITEM = '0;
	localparam lrbd_pkg::resp_t NO_RESP = '0;
	localparam int PLAN_ROWS = 26;
	localparam step_row_t PLAN [PLAN_ROWS] = '{
		'{ROW_ITEM, '{KIND_DRAIN, 8'h00, 1'b0, 8'h00}, 7'd0, 1'b1, '{8'h00, 8'h00, 1'b1, 1'b1}},
		'{ROW_ITEM, '{KIND_PUT, 8'hFF, 1'b1, 8'hFF}, 7'd0, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_SET, 8'h00, 1'b0, 8'h00}, 7'd0, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_SET, 8'hFF, 1'b1, 8'hFF}, 7'd0, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_PUT, 8'h00, 1'b0, 8'h00}, 7'd0, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_PUT, 8'hFF, 1'b0, 8'h00}, 7'd0, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_PUT, 8'hA5, 1'b1, 8'h5A}, 7'd0, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_DRAIN, 8'h00, 1'b1, 8'hFF}, 7'd0, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_DRAIN, 8'hFF, 1'b0, 8'h5A}, 7'd0, 1'b1, '{8'h5A, 8'h00, 1'b1, 1'b1}},
		'{ROW_ITEM, '{KIND_SPARE, 8'hFF, 1'b1, 8'hFF}, 7'd0, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_PUT, 8'h3C, 1'b0, 8'h00}, 7'd0, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_PUT, 8'hC3, 1'b1, 8'hFF}, 7'd0, 1'b0, NO_RESP},
		'{ROW_CFG, NO_ITEM, 7'd1, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_DRAIN, 8'h00, 1'b0, 8'h11}, 7'd0, 1'b1, '{8'h11, 8'h00, 1'b1, 1'b1}},
		'{ROW_CFG, NO_ITEM, 7'd0, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_DRAIN, 8'h00, 1'b0, 8'h22}, 7'd0, 1'b1, '{8'h22, 8'h00, 1'b1, 1'b1}},
		'{ROW_CFG, NO_ITEM, 7'd2, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_DRAIN, 8'h00, 1'b0, 8'h33}, 7'd0, 1'b0, NO_RESP},
		'{ROW_CFG, NO_ITEM, 7'd127, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_DRAIN, 8'h00, 1'b0, 8'h44}, 7'd0, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_SET, 8'h00, 1'b1, 8'h00}, 7'd0, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_PUT, 8'h7E, 1'b0, 8'h00}, 7'd0, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_SET, 8'hFF, 1'b0, 8'hFF}, 7'd0, 1'b0, NO_RESP},
		'{ROW_ITEM, '{KIND_DRAIN, 8'h00, 1'b0, 8'h80}, 7'd0, 1'b1, '{8'h80, 8'h00, 1'b1, 1'b1}},
		'{ROW_ITEM, '{KIND_PUT, 8'h01, 1'b1, 8'h00}, 7'd0, 1'b0, NO_RESP},
		'{ROW_CFG, NO_ITEM, 7'd64, 1'b0, NO_RESP}
	};

	localparam int PHASES = 8;
	localparam logic [lrbd_pkg::MP_W-1:0] PHASE_PAY [6] =
		'{7'd64, 7'd1, 7'd0, 7'd2, 7'd127, 7'd65};

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	lrbd_pkg::item_t item;
	logic resp_valid;
	logic resp_stall = 1'b0;
	lrbd_pkg::resp_t resp;
	logic cfg_we;
	logic [lrbd_pkg::MP_W-1:0] cfg_wdata;

	log_ring_buffer_with_drain dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.resp_valid(resp_valid),
		.resp_stall(resp_stall),
		.resp(resp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	logic [7:0] ring_mem [lrbd_pkg::BUFFER_DEPTH];
	int unsigned wr_at;
	int unsigned rd_at;
	bit ring_busy;
	bit ovf_latched;
	bit log_en;
	logic [lrbd_pkg::MP_W-1:0] pay_limit;
	bit took_effect;
	lrbd_pkg::resp_t owed_bytes [$];

	int unsigned cycle_count = 0;
	int unsigned errors = 0;
	int unsigned n_in = 0;
	int unsigned n_out = 0;
	int unsigned n_ovf_reports = 0;
	int unsigned n_cfg = 0;
	int unsigned burst_left = 0;
	bit gaps_on = 1'b1;
	int unsigned hold_reqs = 0;
	int unsigned holds_done = 0;
	int unsigned hold_left = 0;
	int unsigned seg_left = 0;
	logic [1:0] stall_style = 2'd0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void apply_to_ring(input lrbd_pkg::item_t it);
		int unsigned lim;
		int unsigned avail;
		int unsigned n;
		int unsigned nxt;
		int unsigned i;
		lrbd_pkg::resp_t r;
		took_effect = 1'b0;
		case (it.kind)
			KIND_PUT: begin
				if (log_en && !(ring_busy && wr_at == rd_at)) begin
					took_effect = 1'b1;
					if (!ring_busy) begin
						rd_at = wr_at;
						ring_busy = 1'b1;
					end
					nxt = (wr_at + 1) % lrbd_pkg::BUFFER_DEPTH;
					if (nxt == rd_at) begin
						ovf_latched = 1'b1;
						ring_mem[wr_at] = 8'h00;
					end else begin
						ring_mem[wr_at] = it.byte_in;
					end
					wr_at = nxt;
				end
			end
			KIND_SET: begin
				if (it.enable != log_en) begin
					took_effect = 1'b1;
					log_en = it.enable;
					ovf_latched = 1'b0;
					wr_at = 0;
					rd_at = 0;
					ring_busy = 1'b0;
				end
			end
			KIND_DRAIN: begin
				took_effect = 1'b1;
				lim = pay_limit;
				if (lim < 1) lim = 1;
				if (lim > lrbd_pkg::PAYLOAD_CAP) lim = lrbd_pkg::PAYLOAD_CAP;
				if (!ring_busy)
					avail = 0;
				else if (wr_at == rd_at)
					avail = lrbd_pkg::BUFFER_DEPTH;
				else
					avail = (wr_at + lrbd_pkg::BUFFER_DEPTH - rd_at)
						% lrbd_pkg::BUFFER_DEPTH;
				n = (avail < lim - 1) ? avail : lim - 1;
				r.token_out = it.token;
				r.data_out = {7'd0, ovf_latched};
				r.is_flags = 1'b1;
				r.last = (n == 0);
				owed_bytes.push_back(r);
				if (ovf_latched) n_ovf_reports++;
				ovf_latched = 1'b0;
				for (i = 0; i < n; i++) begin
					r.data_out = ring_mem[rd_at];
					r.is_flags = 1'b0;
					r.last = (i + 1 == n);
					owed_bytes.push_back(r);
					rd_at = (rd_at + 1) % lrbd_pkg::BUFFER_DEPTH;
				end
				if (n > 0 && rd_at == wr_at) begin
					wr_at = 0;
					rd_at = 0;
					ring_busy = 1'b0;
				end
			end
			default: begin
			end
		endcase
	endfunction

	task automatic send(input lrbd_pkg::item_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = gaps_on ? $urandom_range(0, 7) : 0;
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		n_in++;
		apply_to_ring(it);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		burst_left = 0;
		while (owed_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [lrbd_pkg::MP_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pay_limit = v;
		n_cfg++;
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > WATCHDOG_CYCLES) begin
			$display("tb_log_ring_buffer_with_drain: errors");
			$finish;
		end
	end

	// hold off on request, else stall by segment style
	always @(posedge clk) begin
		if (hold_left > 0) begin
			resp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_reqs != holds_done) begin
			holds_done <= holds_done + 1;
			hold_left <= LONG_HOLD_CYCLES;
			resp_stall <= 1'b1;
		end else begin
			if (seg_left == 0) begin
				seg_left <= $urandom_range(20, 200);
				stall_style <= 2'($urandom_range(0, 2));
			end else begin
				seg_left <= seg_left - 1;
			end
			case (stall_style)
				2'd1: resp_stall <= ($urandom_range(0, 2) == 0);
				2'd2: resp_stall <= STALL_PATTERN[cycle_count % 16];
				default: resp_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin : watch_resp
		lrbd_pkg::resp_t want;
		if (arst_n && resp_valid && !resp_stall) begin
			if (owed_bytes.size() == 0) begin
				$error("result with nothing expected: %h", resp);
				errors++;
			end else begin
				want = owed_bytes.pop_front();
				n_out++;
				check_field("token_out", want.token_out, resp.token_out);
				check_field("data_out", want.data_out, resp.data_out);
				check_field("is_flags", {7'd0, want.is_flags}, {7'd0, resp.is_flags});
				check_field("last", {7'd0, want.last}, {7'd0, resp.last});
			end
		end
	end

	initial begin : stimulus
		lrbd_pkg::item_t it;
		int unsigned roll;
		int unsigned useful;
		logic [lrbd_pkg::MP_W-1:0] pay;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		wr_at = 0;
		rd_at = 0;
		ring_busy = 1'b0;
		ovf_latched = 1'b0;
		log_en = 1'b0;
		pay_limit = 7'd64;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < PLAN_ROWS; r++) begin
			if (PLAN[r].what == ROW_CFG) begin
				write_cfg(PLAN[r].cfg);
			end else begin
				send(PLAN[r].it);
				if (PLAN[r].typed) begin
					void'(owed_bytes.pop_back());
					owed_bytes.push_back(PLAN[r].exp);
				end
			end
		end

		// hold off the receiver while drains keep coming so both queues back up
		it = '0;
		it.kind = KIND_SET;
		it.enable = 1'b1;
		send(it);
		for (int k = 0; k < 30; k++) begin
			it.kind = KIND_PUT;
			it.byte_in = 8'($urandom);
			it.enable = 1'($urandom);
			it.token = 8'($urandom);
			send(it);
		end
		hold_reqs++;
		gaps_on = 1'b0;
		for (int k = 0; k < 12; k++) begin
			it.kind = KIND_DRAIN;
			it.byte_in = 8'($urandom);
			it.token = 8'($urandom);
			send(it);
		end
		settle();

		for (int p = 0; p < PHASES; p++) begin
			pay = (p < 6) ? PHASE_PAY[p] : 7'($urandom_range(0, 127));
			write_cfg(pay);
			gaps_on = (p % 3 != 2);
			useful = 0;
			while (useful < 10) begin
				roll = $urandom_range(0, 99);
				it.byte_in = 8'($urandom);
				it.enable = 1'($urandom);
				it.token = 8'($urandom);
				if (roll < 58) begin
					it.kind = KIND_PUT;
				end else if (roll < 80) begin
					it.kind = KIND_DRAIN;
				end else if (roll < 93) begin
					it.kind = KIND_SET;
					it.enable = ($urandom_range(0, 3) != 0);
				end else begin
					it.kind = KIND_SPARE;
				end
				send(it);
				if (took_effect) useful++;
				if ($urandom_range(0, 39) == 0) settle();
			end
		end

		settle();
		repeat (16) @(posedge clk);
		$display("Run: %0d transfers in, %0d response bytes checked, %0d max_payload writes.",
			n_in, n_out, n_cfg);
		$display("Overflow reported on %0d drains; long receiver hold backed up both queues.",
			n_ovf_reports);
		if (errors == 0) begin
			$display("tb_log_ring_buffer_with_drain: clean");
		end else begin
			$display("tb_log_ring_buffer_with_drain: errors");
		end
		$finish;
	end

endmodule
